// ===== rtl/mi3_pkg.sv =====
// Shared types, widths and cofactor tables for the 3x3 adjugate matrix inverse.
// Used by every module under rtl/; depends on nothing.
package mi3_pkg;

	localparam int DW = 32;                  // element width
	localparam int FB = 16;                  // fraction bits
	localparam int PW = 2 * DW;              // element product
	localparam int CW = 2 * DW + 1;          // 2x2 cofactor
	localparam int DETW = DW + CW + 2;       // determinant, three terms
	localparam int NUMW0 = (CW + 2 * FB > DETW) ? CW + 2 * FB : DETW;
	localparam int NW = NUMW0 + 1;           // divider numerator / remainder
	localparam int DVW = NW + DW;            // shifted divisor compare width
	localparam int QB = DW;                  // quotient bits before saturation
	localparam int NLANE = 9;
	localparam int NRES = NLANE + 1;         // nine inverse elements plus determinant
	localparam int DET_IDX = NLANE;

	typedef logic signed [DW-1:0] elem_t;

	// Element indexes (row-major) for cofactor k = a[0]*a[1] - a[2]*a[3]
	localparam int COF_IDX [9][4] = '{
		'{4, 8, 5, 7}, '{3, 8, 5, 6}, '{3, 7, 4, 6},
		'{1, 8, 2, 7}, '{0, 8, 2, 6}, '{0, 7, 1, 6},
		'{1, 5, 2, 4}, '{0, 5, 2, 3}, '{0, 4, 1, 3}
	};
	// Cofactors that carry a minus sign (checkerboard)
	localparam logic [8:0] COF_NEG = 9'b010101010;

	// Magnitude result ready for saturation in the merge stage
	typedef struct packed {
		logic [DW-1:0] quot;
		logic          big;
		logic          neg;
	} lane_res_t;

endpackage

// ===== rtl/mi3_front.sv =====
// Front pipeline: element products, 2x2 cofactors and exact determinant (s1..s4).
// Depends on mi3_pkg.
module mi3_front (
	input  logic                          clk,
	input  logic                          advance,
	input  mi3_pkg::elem_t                m [9],
	output logic signed [mi3_pkg::CW-1:0] cof [9],
	output logic signed [mi3_pkg::DETW-1:0] det
);

	logic signed [mi3_pkg::PW-1:0] pa_s1 [9];
	logic signed [mi3_pkg::PW-1:0] pb_s1 [9];
	mi3_pkg::elem_t arow_s1 [3];
	mi3_pkg::elem_t arow_s2 [3];
	logic signed [mi3_pkg::CW-1:0] cof_s2 [9];
	logic signed [mi3_pkg::CW-1:0] cof_s3 [9];
	logic signed [mi3_pkg::CW-1:0] cof_s4 [9];
	logic signed [2*mi3_pkg::DW:0] pplo_s3 [3];
	logic signed [2*mi3_pkg::DW:0] pphi_s3 [3];
	logic signed [mi3_pkg::DETW-1:0] det_s4;
	logic signed [mi3_pkg::CW-1:0] diff [9];
	logic signed [mi3_pkg::DETW-1:0] term [3];

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < 9; k++) begin
				pa_s1[k] <= m[mi3_pkg::COF_IDX[k][0]] * m[mi3_pkg::COF_IDX[k][1]];
				pb_s1[k] <= m[mi3_pkg::COF_IDX[k][2]] * m[mi3_pkg::COF_IDX[k][3]];
			end
			for (int i = 0; i < 3; i++) begin
				arow_s1[i] <= m[i];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			diff[k] = mi3_pkg::CW'(pa_s1[k]) - mi3_pkg::CW'(pb_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < 9; k++) begin
				cof_s2[k] <= mi3_pkg::COF_NEG[k] ? -diff[k] : diff[k];
			end
			arow_s2 <= arow_s1;
		end
	end

	// split each first-row cofactor into unsigned low and signed high halves
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				pplo_s3[i] <= arow_s2[i] * $signed({1'b0, cof_s2[i][mi3_pkg::DW-1:0]});
				pphi_s3[i] <= arow_s2[i] * $signed(cof_s2[i][mi3_pkg::CW-1:mi3_pkg::DW]);
			end
			cof_s3 <= cof_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			term[i] = (mi3_pkg::DETW'(pphi_s3[i]) <<< mi3_pkg::DW) + mi3_pkg::DETW'(pplo_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			det_s4 <= term[0] + term[1] + term[2];
			cof_s4 <= cof_s3;
		end
	end

	assign cof = cof_s4;
	assign det = det_s4;

endmodule

// ===== rtl/mi3_div_lane.sv =====
// One division lane: range check, then one restoring quotient bit per stage.
// Depends on mi3_pkg.
module mi3_div_lane (
	input  logic                     clk,
	input  logic                     advance,
	input  logic [mi3_pkg::NW-1:0]   num,
	input  logic [mi3_pkg::NW-1:0]   den,
	input  logic                     neg,
	output mi3_pkg::lane_res_t       res
);

	logic [mi3_pkg::NW-1:0] rem_s [mi3_pkg::QB+1];
	logic [mi3_pkg::NW-1:0] den_s [mi3_pkg::QB+1];
	logic [mi3_pkg::DW-1:0] quo_s [mi3_pkg::QB+1];
	logic                   neg_s [mi3_pkg::QB+1];
	logic                   big_s [mi3_pkg::QB+1];

	// quotient that needs more than DW bits saturates anyway
	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			neg_s[0] <= neg;
			quo_s[0] <= '0;
			big_s[0] <= mi3_pkg::DVW'(num) >= (mi3_pkg::DVW'(den) << mi3_pkg::QB);
		end
	end

	for (genvar t = 1; t <= mi3_pkg::QB; t++) begin : g_bit
		localparam int K = mi3_pkg::QB - t;
		logic [mi3_pkg::DVW-1:0] sh;
		logic [mi3_pkg::DVW-1:0] dif;
		logic                    ge;

		always_comb begin
			sh  = mi3_pkg::DVW'(den_s[t-1]) << K;
			ge  = mi3_pkg::DVW'(rem_s[t-1]) >= sh;
			dif = mi3_pkg::DVW'(rem_s[t-1]) - sh;
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[t] <= ge ? dif[mi3_pkg::NW-1:0] : rem_s[t-1];
				quo_s[t] <= quo_s[t-1] | (ge ? (mi3_pkg::DW'(1) << K) : '0);
				den_s[t] <= den_s[t-1];
				neg_s[t] <= neg_s[t-1];
				big_s[t] <= big_s[t-1];
			end
		end
	end

	assign res.quot = quo_s[mi3_pkg::QB];
	assign res.big  = big_s[mi3_pkg::QB];
	assign res.neg  = neg_s[mi3_pkg::QB];

endmodule

// ===== rtl/mi3_merge.sv =====
// Merge stage: saturate and sign all ten results, gather overflow, apply singular.
// Depends on mi3_pkg.
module mi3_merge (
	input  logic                   clk,
	input  logic                   advance,
	input  mi3_pkg::lane_res_t     res [mi3_pkg::NRES],
	input  logic                   sing,
	output logic [mi3_pkg::DW-1:0] val_q [mi3_pkg::NRES],
	output logic                   sing_q,
	output logic                   ovf_q
);

	localparam logic [mi3_pkg::DW-1:0] HALF = mi3_pkg::DW'(1) << (mi3_pkg::DW - 1);

	logic [mi3_pkg::DW-1:0] lim [mi3_pkg::NRES];
	logic [mi3_pkg::DW-1:0] mag [mi3_pkg::NRES];
	logic [mi3_pkg::DW-1:0] sgn [mi3_pkg::NRES];
	logic [mi3_pkg::NRES-1:0] sat;

	always_comb begin
		for (int e = 0; e < mi3_pkg::NRES; e++) begin
			lim[e] = res[e].neg ? HALF : HALF - 1'b1;
			sat[e] = res[e].big || (res[e].quot > lim[e]);
			mag[e] = sat[e] ? lim[e] : res[e].quot;
			sgn[e] = res[e].neg ? (~mag[e] + 1'b1) : mag[e];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int e = 0; e < mi3_pkg::NRES; e++) begin
				val_q[e] <= sing ? '0 : sgn[e];
			end
			sing_q <= sing;
			ovf_q  <= !sing && (|sat);
		end
	end

	// a singular result carries no overflow
	a_sing_no_ovf: assert property (@(posedge clk) sing_q |-> !ovf_q)
		else $error("overflow flagged on a singular result");
	a_sing_zero: assert property (@(posedge clk)
		$past(advance) && $past(sing) |-> val_q[mi3_pkg::DET_IDX] == '0 && val_q[0] == '0)
		else $error("singular result not zeroed");
	a_sat_ovf: assert property (@(posedge clk)
		$past(advance) && !$past(sing) && $past(res[mi3_pkg::DET_IDX].big) |-> ovf_q)
		else $error("determinant saturation lost its overflow flag");

endmodule

// ===== rtl/mi3_inverse_top_note.sv =====
// Saturation helper shared nowhere else: flags a result field at negative full scale.
// Depends on mi3_pkg.
module mi3_range_chk (
	input  logic [mi3_pkg::DW-1:0] val,
	output logic                   is_min
);
	assign is_min = (val == (mi3_pkg::DW'(1) << (mi3_pkg::DW - 1)));
endmodule

// ===== rtl/mat3_inverse_adjugate.sv =====
// Top level of the 3x3 fixed-point matrix inverse by adjugate and determinant.
// Depends on mi3_pkg, mi3_front, mi3_div_lane, mi3_merge, mi3_range_chk.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  input   | in_valid / in_ready   | m11..m33, signed Q16.16, row-major
//  output  | out_valid / out_ready | inv11..inv33, determinant, singular, overflow
//
// One matrix per cycle while the output is not stalled; each passes the front
// stages s1..s4, s5, s6, the nine bit-per-stage restoring divider lanes and merge.
// The whole pipeline advances together; it holds only when a result sits in the
// output register and out_ready is low, so in_ready = !out_valid || out_ready.
// Reset (arst_n, asynchronous) clears only the stage valid bits; data registers
// are not reset.
module mat3_inverse_adjugate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mi3_pkg::elem_t m11,
	input  mi3_pkg::elem_t m12,
	input  mi3_pkg::elem_t m13,
	input  mi3_pkg::elem_t m21,
	input  mi3_pkg::elem_t m22,
	input  mi3_pkg::elem_t m23,
	input  mi3_pkg::elem_t m31,
	input  mi3_pkg::elem_t m32,
	input  mi3_pkg::elem_t m33,
	output logic           out_valid,
	input  logic           out_ready,
	output mi3_pkg::elem_t inv11,
	output mi3_pkg::elem_t inv12,
	output mi3_pkg::elem_t inv13,
	output mi3_pkg::elem_t inv21,
	output mi3_pkg::elem_t inv22,
	output mi3_pkg::elem_t inv23,
	output mi3_pkg::elem_t inv31,
	output mi3_pkg::elem_t inv32,
	output mi3_pkg::elem_t inv33,
	output mi3_pkg::elem_t determinant,
	output logic           singular,
	output logic           overflow
);

	// front 4, magnitude 1, numerator 1, divider QB+1, merge 1
	localparam int LAT = 4 + 2 + mi3_pkg::QB + 1 + 1;
	localparam int DLY = mi3_pkg::QB + 1;

	logic                 advance;
	logic [LAT-1:0]       vld_q;
	mi3_pkg::elem_t       m [9];

	logic signed [mi3_pkg::CW-1:0]   cof [9];
	logic signed [mi3_pkg::DETW-1:0] det;

	logic [mi3_pkg::DETW-1:0] dmag_s5;
	logic                     dneg_s5;
	logic                     dzero_s5;
	logic [mi3_pkg::CW-1:0]   cmag_s5 [mi3_pkg::NLANE];
	logic                     neg_s5  [mi3_pkg::NLANE];

	logic [mi3_pkg::NW-1:0]   num_s6 [mi3_pkg::NLANE];
	logic [mi3_pkg::NW-1:0]   den_s6;
	logic                     neg_s6 [mi3_pkg::NLANE];
	mi3_pkg::lane_res_t       detres_s6;
	logic                     dzero_s6;
	logic [mi3_pkg::DETW:0]   drnd;

	mi3_pkg::lane_res_t       detdly_q  [DLY];
	logic                     zerodly_q [DLY];
	mi3_pkg::lane_res_t       res [mi3_pkg::NRES];
	logic [mi3_pkg::DW-1:0]   val_q [mi3_pkg::NRES];
	logic                     det_min;

	// advance the whole pipe unless the output register is full and stalled
	assign advance  = !vld_q[LAT-1] || out_ready;
	assign in_ready = advance;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign m = '{m11, m12, m13, m21, m22, m23, m31, m32, m33};

	mi3_front u_front (
		.clk     (clk),
		.advance (advance),
		.m       (m),
		.cof     (cof),
		.det     (det)
	);

	// s5: magnitudes and signs; lane o = 3*i + j takes cofactor 3*j + i
	always_ff @(posedge clk) begin
		if (advance) begin
			dneg_s5  <= det[mi3_pkg::DETW-1];
			dmag_s5  <= det[mi3_pkg::DETW-1] ? mi3_pkg::DETW'(-det) : mi3_pkg::DETW'(det);
			dzero_s5 <= (det == '0);
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					cmag_s5[3*i+j] <= cof[3*j+i][mi3_pkg::CW-1] ?
						mi3_pkg::CW'(-cof[3*j+i]) : mi3_pkg::CW'(cof[3*j+i]);
					neg_s5[3*i+j]  <= cof[3*j+i][mi3_pkg::CW-1] ^ det[mi3_pkg::DETW-1];
				end
			end
		end
	end

	// s6: rounded numerators (|c| * 2^(2F+1) + |d|) over 2|d|; determinant rounding
	assign drnd = ((mi3_pkg::DETW+1)'(dmag_s5)
		+ ((mi3_pkg::DETW+1)'(1) << (2 * mi3_pkg::FB - 1))) >> (2 * mi3_pkg::FB);

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int o = 0; o < mi3_pkg::NLANE; o++) begin
				num_s6[o] <= (mi3_pkg::NW'(cmag_s5[o]) << (2 * mi3_pkg::FB + 1))
					+ mi3_pkg::NW'(dmag_s5);
				neg_s6[o] <= neg_s5[o];
			end
			den_s6         <= mi3_pkg::NW'(dmag_s5) << 1;
			detres_s6.quot <= drnd[mi3_pkg::DW-1:0];
			detres_s6.big  <= |(drnd >> mi3_pkg::DW);
			detres_s6.neg  <= dneg_s5;
			dzero_s6       <= dzero_s5;
		end
	end

	for (genvar o = 0; o < mi3_pkg::NLANE; o++) begin : g_lane
		mi3_div_lane u_lane (
			.clk     (clk),
			.advance (advance),
			.num     (num_s6[o]),
			.den     (den_s6),
			.neg     (neg_s6[o]),
			.res     (res[o])
		);
	end

	// hold the determinant result alongside the divider lanes
	always_ff @(posedge clk) begin
		if (advance) begin
			detdly_q[0]  <= detres_s6;
			zerodly_q[0] <= dzero_s6;
			for (int t = 1; t < DLY; t++) begin
				detdly_q[t]  <= detdly_q[t-1];
				zerodly_q[t] <= zerodly_q[t-1];
			end
		end
	end

	assign res[mi3_pkg::DET_IDX] = detdly_q[DLY-1];

	mi3_merge u_merge (
		.clk     (clk),
		.advance (advance),
		.res     (res),
		.sing    (zerodly_q[DLY-1]),
		.val_q   (val_q),
		.sing_q  (singular),
		.ovf_q   (overflow)
	);

	assign inv11       = val_q[0];
	assign inv12       = val_q[1];
	assign inv13       = val_q[2];
	assign inv21       = val_q[3];
	assign inv22       = val_q[4];
	assign inv23       = val_q[5];
	assign inv31       = val_q[6];
	assign inv32       = val_q[7];
	assign inv33       = val_q[8];
	assign determinant = val_q[mi3_pkg::DET_IDX];

	mi3_range_chk u_det_chk (
		.val    (val_q[mi3_pkg::DET_IDX]),
		.is_min (det_min)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction missing from the first stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(vld_q))
		else $error("pipeline moved during a stall");
	a_sing_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> inv11 == '0 && inv22 == '0 && inv33 == '0
			&& determinant == '0 && !overflow)
		else $error("singular result not cleared");
	a_min_not_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && det_min |-> !singular)
		else $error("determinant at negative full scale on a singular result");

endmodule
